@@ rtl/pgn_pkg.sv @@
// Package for the 2D gradient noise block: widths, command codes and the
// front-to-back transaction type. No dependencies.
package pgn_pkg;
  localparam int TableSize = 256;
  localparam int FracBitsDefault = 16;
  localparam int OutW = 19;
  localparam int QueueDepth = 4;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [7:0]  xi;
    logic [7:0]  yi;
    logic [23:0] xf;
    logic [23:0] yf;
  } eval_t;
endpackage

@@ rtl/pgn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pgn_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/pgn_front.sv @@
// Front part: takes commands, routes loads to the table write port and
// splits evaluate coordinates into cell index and fraction. Uses pgn_pkg.
module pgn_front #(
  parameter int FracBits = pgn_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic               command,
  input  logic [7:0]         perm_index,
  input  logic [7:0]         perm_value,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  output logic               we,
  output logic [7:0]         waddr,
  output logic [7:0]         wdata,
  output logic               ev_valid,
  output pgn_pkg::eval_t     ev
);
  import pgn_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      we       <= 1'b0;
      ev_valid <= 1'b0;
    end else begin
      we       <= take && (cmd_t'(command) == CMD_LOAD);
      ev_valid <= take && (cmd_t'(command) == CMD_EVAL);
    end
    waddr <= perm_index;
    wdata <= perm_value;
    ev.xi <= x_coord[FracBits +: 8];
    ev.yi <= y_coord[FracBits +: 8];
    ev.xf <= 24'(x_coord[FracBits-1:0]);
    ev.yf <= 24'(y_coord[FracBits-1:0]);
  end
endmodule

@@ rtl/pgn_queue.sv @@
// Short FIFO of evaluate transactions between front and back parts.
// Uses pgn_pkg.
module pgn_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pgn_pkg::eval_t din,
  input  logic           pop,
  output logic           nonempty,
  output pgn_pkg::eval_t dout,
  output logic [$clog2(pgn_pkg::QueueDepth):0] count
);
  import pgn_pkg::*;
  localparam int AW = $clog2(QueueDepth);

  eval_t         slot [QueueDepth];
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;

  assign nonempty = (count != '0);
  assign dout     = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) slot[wr_ptr] <= din;
  end
endmodule

@@ rtl/pgn_back.sv @@
// Back part: fade, table hashing through six RAM copies, gradients and
// bilinear blend, one transaction per cycle. Uses pgn_pkg and pgn_ram.
module pgn_back #(
  parameter int FracBits = pgn_pkg::FracBitsDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  pgn_pkg::eval_t in_ev,
  input  logic           we,
  input  logic [7:0]     waddr,
  input  logic [7:0]     wdata,
  output logic           res_valid,
  output logic signed [pgn_pkg::OutW-1:0] res_value,
  output logic [3:0]     inflight
);
  import pgn_pkg::*;
  localparam int W = (FracBits + 6 > 20) ? FracBits + 6 : 20;
  localparam int PW = 2 * W;
  localparam logic signed [W-1:0] One = W'(1) <<< FracBits;
  localparam logic signed [W-1:0] Ten = W'(10) <<< FracBits;
  localparam logic signed [W-1:0] Fifteen = W'(15) <<< FracBits;
  localparam int NS = 6;

  function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    return W'(p >>> FracBits);
  endfunction

  function automatic logic signed [W-1:0] grad(input logic [7:0] hash,
                                               input logic signed [W-1:0] x,
                                               input logic signed [W-1:0] y);
    logic [5:0] h;
    logic signed [W-1:0] u;
    logic signed [W-1:0] v;
    h = hash[5:0];
    u = (h < 6'd4) ? x : y;
    v = (h < 6'd4) ? y : x;
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  logic [NS-1:0] vld;
  logic signed [W-1:0] xf [2];
  logic signed [W-1:0] yf [2];
  logic signed [W-1:0] xt, yt;
  logic [7:0] yi;
  logic [7:0] px0;
  logic [7:0] px1;
  logic [7:0] ra_addr, rb_addr, rc_addr, rd_addr, re_addr, rf_addr;
  logic [7:0] aa, ab, ba, bb;
  logic       we_late;
  logic [7:0] waddr_late, wdata_late;
  logic signed [W-1:0] fu_in, fv_in, fu_t2, fv_t2, fu_t3, fv_t3, fu_o, fv_o;
  logic signed [W-1:0] u_q [1:2];
  logic signed [W-1:0] v_q [1:3];
  logic signed [W-1:0] g_aa, g_ab, g_ba, g_bb;
  logic signed [W-1:0] n0, n1, d0, d1, n0b, n1b, r;

  always_comb inflight = 4'($countones(vld));

  pgn_ram #(.Width(8), .Depth(TableSize)) u_ram_a (
    .clk, .we, .waddr, .wdata, .raddr(ra_addr), .rdata(px0));
  pgn_ram #(.Width(8), .Depth(TableSize)) u_ram_b (
    .clk, .we, .waddr, .wdata, .raddr(rb_addr), .rdata(px1));
  pgn_ram #(.Width(8), .Depth(TableSize)) u_ram_c (
    .clk, .we(we_late), .waddr(waddr_late), .wdata(wdata_late), .raddr(rc_addr),
    .rdata(aa));
  pgn_ram #(.Width(8), .Depth(TableSize)) u_ram_d (
    .clk, .we(we_late), .waddr(waddr_late), .wdata(wdata_late), .raddr(rd_addr),
    .rdata(ab));
  pgn_ram #(.Width(8), .Depth(TableSize)) u_ram_e (
    .clk, .we(we_late), .waddr(waddr_late), .wdata(wdata_late), .raddr(re_addr),
    .rdata(ba));
  pgn_ram #(.Width(8), .Depth(TableSize)) u_ram_f (
    .clk, .we(we_late), .waddr(waddr_late), .wdata(wdata_late), .raddr(rf_addr),
    .rdata(bb));

  assign xt = W'(in_ev.xf[FracBits-1:0]);
  assign yt = W'(in_ev.yf[FracBits-1:0]);
  assign ra_addr = in_ev.xi;
  assign rb_addr = in_ev.xi + 8'd1;
  assign rc_addr = px0 + yi;
  assign rd_addr = px0 + yi + 8'd1;
  assign re_addr = px1 + yi;
  assign rf_addr = px1 + yi + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      we_late <= 1'b0;
    end else begin
      vld     <= {vld[NS-2:0], in_valid};
      we_late <= we;
    end
    waddr_late <= waddr;
    wdata_late <= wdata;
    xf[0] <= xt;
    yf[0] <= yt;
    yi <= in_ev.yi;
    xf[1] <= xf[0];
    yf[1] <= yf[0];
    // fade: stage 1 inner poly, 2 t^3, 3 product
    fu_in <= fmul(xt, (xt <<< 2) + (xt <<< 1) - Fifteen) + Ten;
    fv_in <= fmul(yt, (yt <<< 2) + (yt <<< 1) - Fifteen) + Ten;
    fu_t2 <= fmul(xt, xt);
    fv_t2 <= fmul(yt, yt);
    fu_t3 <= fmul(fu_t2, xf[0]);
    fv_t3 <= fmul(fv_t2, yf[0]);
    u_q[1] <= fu_in;
    v_q[1] <= fv_in;
    fu_o <= fmul(fu_t3, u_q[1]);
    fv_o <= fmul(fv_t3, v_q[1]);
    u_q[2] <= fu_o;
    v_q[2] <= fv_o;
    v_q[3] <= v_q[2];
    // corner hashes valid at stage 2 outputs; gradients at stage 3
    g_aa <= grad(aa, xf[1], yf[1]);
    g_ba <= grad(ba, xf[1] - One, yf[1]);
    g_ab <= grad(ab, xf[1], yf[1] - One);
    g_bb <= grad(bb, xf[1] - One, yf[1] - One);
    // blend stage 4 diff, 5 product+add
    d0 <= g_ba - g_aa;
    d1 <= g_bb - g_ab;
    n0 <= g_aa;
    n1 <= g_ab;
    n0b <= n0 + fmul(u_q[2], d0);
    n1b <= n1 + fmul(u_q[2], d1);
    r <= n0b + fmul(v_q[3], n1b - n0b);
  end

  localparam logic signed [W-1:0] OMax = W'(262143);
  localparam logic signed [W-1:0] OMin = -W'(262144);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= vld[5];
    end
    if (r > OMax) res_value <= OutW'(OMax);
    else if (r < OMin) res_value <= OutW'(OMin);
    else res_value <= OutW'(r);
  end
endmodule

@@ rtl/perlin_gradient_noise_2d.sv @@
// Top level of the 2D gradient noise block: front part, transaction queue
// and back part. Uses pgn_pkg, pgn_front, pgn_queue, pgn_back.
//
//  channel   signals                                         direction
//  command   start, busy, command, perm_index, perm_value,   in
//            x_coord, y_coord
//  result    noise_strobe, noise_value                       out
//
// One transaction per cycle. The strobe for an evaluate command rises after
// the front register, the queue slot and the back pipeline registers. Load
// commands give no result. busy stays low, since queue and pipeline never
// back up; the receiver cannot stall. Reset clears control.
module perlin_gradient_noise_2d #(
  parameter int FracBits = pgn_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [7:0]         perm_index,
  input  logic [7:0]         perm_value,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  output logic               noise_strobe,
  output logic signed [pgn_pkg::OutW-1:0] noise_value
);
  import pgn_pkg::*;

  logic take, we, ev_valid, q_ne, back_valid;
  logic [7:0] waddr, wdata;
  eval_t ev, q_ev;
  logic [$clog2(QueueDepth):0] q_count;
  logic [3:0] inflight;

  assign busy = 1'b0;
  assign take = start && !busy;
  assign back_valid = q_ne;

  pgn_front #(.FracBits(FracBits)) u_front (
    .clk, .rst, .take, .command, .perm_index, .perm_value, .x_coord,
    .y_coord, .we, .waddr, .wdata, .ev_valid, .ev);

  pgn_queue u_queue (
    .clk, .rst, .push(ev_valid), .din(ev), .pop(q_ne), .nonempty(q_ne),
    .dout(q_ev), .count(q_count));

  pgn_back #(.FracBits(FracBits)) u_back (
    .clk, .rst, .in_valid(back_valid), .in_ev(q_ev), .we, .waddr, .wdata,
    .res_valid(noise_strobe), .res_value(noise_value), .inflight);

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= 1) else $error("queue overfill");
  a_no_strobe_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !noise_strobe) else $error("strobe after reset");
  a_inflight: assert property (@(posedge clk) disable iff (rst)
    inflight <= 4'd6) else $error("pipeline count");
endmodule

@@ sim/pgn_checker.sv @@
// Checker for the 2D gradient noise block: watches the command and result
// channels, predicts noise values and compares them. Uses pgn_pkg.
module pgn_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               command,
  input  logic [7:0]         perm_index,
  input  logic [7:0]         perm_value,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  logic               noise_strobe,
  input  logic signed [pgn_pkg::OutW-1:0] noise_value,
  output int                 fail_count,
  output int                 pending
);
  import pgn_pkg::*;

  localparam int Frac = FracBitsDefault;
  localparam longint One = longint'(1) << Frac;

  logic [7:0] perm_copy [TableSize];
  logic signed [OutW-1:0] noise_queue [$];

  function automatic longint floor_shift(longint v);
    return v >>> Frac;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return floor_shift(a * b);
  endfunction

  function automatic longint fade(longint t);
    longint inner, t2, t3;
    inner = fx_mul(t, 6 * t - 15 * One) + 10 * One;
    t2 = fx_mul(t, t);
    t3 = fx_mul(t2, t);
    return fx_mul(t3, inner);
  endfunction

  function automatic longint lerp(longint a, longint b, longint t);
    return a + fx_mul(t, b - a);
  endfunction

  function automatic longint grad(logic [7:0] hash, longint gx, longint gy);
    logic [5:0] h;
    longint u, v;
    h = hash[5:0];
    u = (h < 4) ? gx : gy;
    v = (h < 4) ? gy : gx;
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  function automatic logic signed [OutW-1:0] noise_at(logic [31:0] xr, logic [31:0] yr);
    logic [7:0] xi, yi, px0, px1, aa, ab, ba, bb;
    longint xf, yf, u, v, n0, n1, r;
    xi = xr[Frac +: 8];
    yi = yr[Frac +: 8];
    xf = longint'(xr[Frac-1:0]);
    yf = longint'(yr[Frac-1:0]);
    u = fade(xf);
    v = fade(yf);
    px0 = perm_copy[xi];
    px1 = perm_copy[8'(xi + 8'd1)];
    aa = perm_copy[8'(px0 + yi)];
    ab = perm_copy[8'(px0 + yi + 8'd1)];
    ba = perm_copy[8'(px1 + yi)];
    bb = perm_copy[8'(px1 + yi + 8'd1)];
    n0 = lerp(grad(aa, xf, yf), grad(ba, xf - One, yf), u);
    n1 = lerp(grad(ab, xf, yf - One), grad(bb, xf - One, yf - One), u);
    r = lerp(n0, n1, v);
    if (r > 262143) r = 262143;
    if (r < -262144) r = -262144;
    return r[OutW-1:0];
  endfunction

  assign pending = noise_queue.size();

  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
      noise_queue.delete();
    end else begin
      if (noise_strobe) begin
        if (noise_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected noise result %0d", noise_value);
          fail_count <= fail_count + 1;
        end else begin
          if (noise_value !== noise_queue[0]) begin
            if (fail_count < 10)
              $display("noise mismatch: expected %0d actual %0d", noise_queue[0], noise_value);
            fail_count <= fail_count + 1;
          end
          void'(noise_queue.pop_front());
        end
      end
      if (start && !busy) begin
        if (command == CMD_LOAD) perm_copy[perm_index] = perm_value;
        else noise_queue.push_back(noise_at(x_coord, y_coord));
      end
    end
  end
endmodule

@@ sim/tb_perlin_gradient_noise_2d.sv @@
// Testbench top for perlin_gradient_noise_2d: drives load and evaluate
// transactions in phases with and without idle cycles and gives the verdict. Uses pgn_checker.
module tb_perlin_gradient_noise_2d;
  import pgn_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic command = CMD_LOAD;
  logic [7:0] perm_index = '0;
  logic [7:0] perm_value = '0;
  logic signed [31:0] x_coord = '0;
  logic signed [31:0] y_coord = '0;
  logic noise_strobe;
  logic signed [OutW-1:0] noise_value;
  int fail_count, pending;
  int quiet_cycles = 0;
  int idle_pct = 0;
  logic [31:0] dir_x [8] = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h0000_8000, 32'hFFFF_0000, 32'h00FF_FFFF, 32'h0001_0000};

  always #5 clk = ~clk;

  perlin_gradient_noise_2d dut (.*);

  pgn_checker u_checker (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || noise_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("tb_perlin_gradient_noise_2d: errors");
      $finish;
    end
  end

  task automatic issue(logic cmd, logic [7:0] idx, logic [7:0] val, logic [31:0] xv,
                       logic [31:0] yv);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    perm_index <= idx;
    perm_value <= val;
    x_coord <= xv;
    y_coord <= yv;
    do @(posedge clk); while (busy);
  endtask

  task automatic load_table(bit ident);
    logic [7:0] shuffle [256];
    logic [7:0] tmp;
    int j;
    for (int i = 0; i < 256; i++) shuffle[i] = ident ? 8'(i) : 8'(255 - i);
    if (!ident)
      for (int i = 255; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = shuffle[i];
        shuffle[i] = shuffle[j];
        shuffle[j] = tmp;
      end
    for (int i = 0; i < 256; i++) issue(CMD_LOAD, 8'(i), shuffle[i], $urandom, $urandom);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_table(1'b1);
    for (int i = 0; i < 8; i++)
      for (int k = 0; k < 2; k++)
        issue(CMD_EVAL, 8'hFF, 8'hFF, dir_x[i], dir_x[(i + 3 * k) % 8]);
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 50 : (phase == 3) ? 14 : 0;
      if (phase == 0) load_table(1'b0);
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(9) == 0)
          issue(CMD_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom);
        else if ($urandom_range(3) == 0)
          issue(CMD_EVAL, 8'($urandom), 8'($urandom), $urandom, $urandom);
        else
          issue(CMD_EVAL, 8'($urandom), 8'($urandom),
                {{16{1'b0}}, 8'($urandom), 8'($urandom)} - 32'h0080_0000
                  + $urandom_range(65535) * 256,
                $urandom);
      end
      drain();
    end
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("tb_perlin_gradient_noise_2d: clean");
    else $display("tb_perlin_gradient_noise_2d: errors");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/pgn_pkg.sv
rtl/pgn_ram.sv
rtl/pgn_front.sv
rtl/pgn_queue.sv
rtl/pgn_back.sv
rtl/perlin_gradient_noise_2d.sv
sim/pgn_checker.sv
sim/tb_perlin_gradient_noise_2d.sv
